@@ design/ppa_pkg.sv @@
// Shared types, codes and constants for the pairwise proximity alert unit.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package ppa_pkg;

    localparam int MAX_SLOTS = 8;
    localparam int SLOT_W    = 3;
    localparam int POS_W     = 24;
    localparam int DIFF_W    = POS_W + 1;
    localparam int MAG_W     = POS_W;
    localparam int COS_W     = 31;
    localparam int PROD_W    = COS_W + MAG_W;
    localparam int SQ_W      = 2 * MAG_W + 1;
    localparam int DIST_W    = 16;
    localparam int SECT_W    = 7;
    localparam int K_W       = 5;
    localparam int ROOT_CNT_W = 4;

    localparam logic [SECT_W-1:0] HALF_TURN = 7'd36;
    localparam logic [SECT_W-1:0] QUAD_SECTORS = 7'd18;
    localparam logic [K_W-1:0] K_FIRST = 5'd1;
    localparam logic [K_W-1:0] K_LAST  = 5'd17;
    localparam logic [K_W-1:0] K_QUARTER = 5'd18;

    localparam logic [1:0] KIND_REGISTER = 2'd0;
    localparam logic [1:0] KIND_UPDATE   = 2'd1;
    localparam logic [1:0] KIND_CHECK    = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic [SLOT_W-1:0]       slot;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } ppa_in_t;

    typedef struct packed {
        logic [SLOT_W-1:0] own_slot;
        logic [SLOT_W-1:0] intruder_slot;
        logic [DIST_W-1:0] distance_cm;
        logic [SECT_W-1:0] sector;
        logic              last;
    } ppa_out_t;

    typedef struct packed {
        logic              take;
        logic              diff;
        logic              sqx;
        logic              sqy;
        logic              sqrt_init;
        logic              sqrt_step;
        logic              prod_v;
        logic              prod_u;
        logic              out_a;
        logic              out_held;
        logic              last;
        logic [SLOT_W-1:0] i;
        logic [SLOT_W-1:0] j;
        logic [K_W-1:0]    k;
    } ppa_cmd_t;

    typedef struct packed {
        logic                 ge2;
        logic [MAX_SLOTS-1:0] active;
        logic                 close;
        logic                 out_free;
    } ppa_status_t;

    // cos(5k degrees) scaled by 2^30, rounded to nearest.
    function automatic logic [COS_W-1:0] cosq(input logic [K_W-1:0] k);
        logic [COS_W-1:0] c;
        case (k)
            5'd0:    c = 31'd1073741824;
            5'd1:    c = 31'd1069655912;
            5'd2:    c = 31'd1057429273;
            5'd3:    c = 31'd1037154959;
            5'd4:    c = 31'd1008987269;
            5'd5:    c = 31'd973140579;
            5'd6:    c = 31'd929887697;
            5'd7:    c = 31'd879557810;
            5'd8:    c = 31'd822533958;
            5'd9:    c = 31'd759250125;
            5'd10:   c = 31'd690187940;
            5'd11:   c = 31'd615873009;
            5'd12:   c = 31'd536870912;
            5'd13:   c = 31'd453782903;
            5'd14:   c = 31'd367241333;
            5'd15:   c = 31'd277904834;
            5'd16:   c = 31'd186453311;
            5'd17:   c = 31'd93582766;
            default: c = 31'd0;
        endcase
        return c;
    endfunction

endpackage

@@ design/ppa_datapath.sv @@
// Datapath: slot table, threshold, shared multiplier, square root, sector search
// and the output and held-result registers. Depends on ppa_pkg.
`timescale 1ns / 1ps

module ppa_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ppa_pkg::ppa_in_t    in_data,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data,
    input  ppa_pkg::ppa_cmd_t   cmd,
    output ppa_pkg::ppa_status_t status,
    output logic                out_valid,
    input  logic                out_stall,
    output ppa_pkg::ppa_out_t   out_data
);
    import ppa_pkg::*;

    logic [15:0]              thr_reg;
    logic [31:0]              lim_reg;
    logic [MAX_SLOTS-1:0]     active_reg;
    logic signed [POS_W-1:0]  x_reg [MAX_SLOTS];
    logic signed [POS_W-1:0]  y_reg [MAX_SLOTS];
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic [2*MAG_W-1:0]       sqx_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [31:0]              rad_reg;
    logic [17:0]              rem_reg;
    logic [DIST_W-1:0]        root_reg;
    logic [PROD_W-1:0]        pv_reg;
    logic [K_W-1:0]           m_reg;
    logic                     out_valid_reg;
    ppa_out_t                 out_reg;
    ppa_out_t                 held_reg;

    logic [MAG_W-1:0]  mag_x, mag_y, u_mag, v_mag;
    logic [1:0]        quad;
    logic              zero;
    logic [COS_W-1:0]  mul_a;
    logic [MAG_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;
    logic [19:0]       rem_sh;
    logic [17:0]       trial;
    logic [SECT_W-1:0] sect_a, sect_b;
    logic [SLOT_W:0]   slot_ext;

    assign mag_x = dx_reg[DIFF_W-1] ? MAG_W'(-dx_reg) : MAG_W'(dx_reg);
    assign mag_y = dy_reg[DIFF_W-1] ? MAG_W'(-dy_reg) : MAG_W'(dy_reg);
    assign zero  = (dx_reg == '0) && (dy_reg == '0);

    always_comb
    begin
        if (dx_reg > 0 && dy_reg >= 0)
            quad = 2'd0;
        else if (dx_reg <= 0 && dy_reg > 0)
            quad = 2'd1;
        else if (dx_reg < 0 && dy_reg <= 0)
            quad = 2'd2;
        else
            quad = 2'd3;
    end

    // Odd quadrants swap the roles of the two magnitudes.
    assign u_mag = quad[0] ? mag_y : mag_x;
    assign v_mag = quad[0] ? mag_x : mag_y;

    always_comb
    begin
        if (cmd.sqx)
        begin
            mul_a = COS_W'(mag_x);
            mul_b = mag_x;
        end
        else if (cmd.sqy)
        begin
            mul_a = COS_W'(mag_y);
            mul_b = mag_y;
        end
        else if (cmd.prod_v)
        begin
            mul_a = cosq(cmd.k);
            mul_b = v_mag;
        end
        else
        begin
            mul_a = cosq(K_QUARTER - cmd.k);
            mul_b = u_mag;
        end
    end

    assign prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign rem_sh = {rem_reg, rad_reg[31:30]};
    assign trial  = {root_reg, 2'b01};

    assign sect_a = zero ? '0 : SECT_W'(QUAD_SECTORS * SECT_W'(quad)) + SECT_W'(m_reg);
    assign sect_b = zero ? '0 :
                    (sect_a >= HALF_TURN ? sect_a - HALF_TURN : sect_a + HALF_TURN);
    assign slot_ext = {1'b0, in_data.slot};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= 16'd1500;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= cfg_data;
            if (cmd.take && slot_ext < (SLOT_W+1)'(MAX_SLOTS)
                && in_data.kind == KIND_REGISTER)
                active_reg[in_data.slot] <= 1'b1;
            if (cmd.out_a || cmd.out_held)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg <= 32'(thr_reg) * 32'(thr_reg);
        if (cmd.take && slot_ext < (SLOT_W+1)'(MAX_SLOTS))
        begin
            if (in_data.kind == KIND_REGISTER && !active_reg[in_data.slot])
            begin
                x_reg[in_data.slot] <= '0;
                y_reg[in_data.slot] <= '0;
            end
            else if (in_data.kind == KIND_UPDATE && active_reg[in_data.slot])
            begin
                x_reg[in_data.slot] <= in_data.pos_x;
                y_reg[in_data.slot] <= in_data.pos_y;
            end
        end
        if (cmd.diff)
        begin
            dx_reg <= DIFF_W'(x_reg[cmd.j]) - DIFF_W'(x_reg[cmd.i]);
            dy_reg <= DIFF_W'(y_reg[cmd.j]) - DIFF_W'(y_reg[cmd.i]);
        end
        if (cmd.sqx)
            sqx_reg <= (2*MAG_W)'(prod);
        if (cmd.sqy)
            sq_reg <= SQ_W'(sqx_reg) + SQ_W'(prod);
        if (cmd.sqrt_init)
        begin
            rad_reg  <= sq_reg[31:0];
            rem_reg  <= '0;
            root_reg <= '0;
            m_reg    <= '0;
        end
        if (cmd.sqrt_step)
        begin
            rad_reg <= {rad_reg[29:0], 2'b00};
            if (rem_sh >= 20'(trial))
            begin
                rem_reg  <= 18'(rem_sh - 20'(trial));
                root_reg <= {root_reg[DIST_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= 18'(rem_sh);
                root_reg <= {root_reg[DIST_W-2:0], 1'b0};
            end
        end
        if (cmd.prod_v)
            pv_reg <= prod;
        if (cmd.prod_u && pv_reg >= prod)
            m_reg <= m_reg + K_W'(1);
        if (cmd.out_a)
        begin
            out_reg  <= '{own_slot: cmd.i, intruder_slot: cmd.j, distance_cm: root_reg,
                          sector: sect_a, last: 1'b0};
            held_reg <= '{own_slot: cmd.j, intruder_slot: cmd.i, distance_cm: root_reg,
                          sector: sect_b, last: 1'b0};
        end
        else if (cmd.out_held)
        begin
            out_reg <= '{own_slot: held_reg.own_slot, intruder_slot: held_reg.intruder_slot,
                         distance_cm: held_reg.distance_cm, sector: held_reg.sector,
                         last: cmd.last};
        end
    end

    assign status.ge2      = ($countones(active_reg) >= 2);
    assign status.active   = active_reg;
    assign status.close    = (sq_reg < SQ_W'(lim_reg));
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ design/ppa_ctrl.sv @@
// Controller: walks the slot pairs of a check beat and sequences the datapath.
// Depends on ppa_pkg.
`timescale 1ns / 1ps

module ppa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ppa_pkg::ppa_in_t     in_data,
    input  ppa_pkg::ppa_status_t status,
    output ppa_pkg::ppa_cmd_t    cmd
);
    import ppa_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_SQX, ST_SQY, ST_CMP, ST_SQRT,
        ST_SECT_V, ST_SECT_U, ST_EMIT_H, ST_EMIT_A, ST_ADV, ST_FINISH
    } state_t;

    localparam logic [SLOT_W-1:0] LAST_I = SLOT_W'(MAX_SLOTS - 2);
    localparam logic [SLOT_W-1:0] LAST_J = SLOT_W'(MAX_SLOTS - 1);

    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     i_reg, i_next, j_reg, j_next;
    logic [K_W-1:0]        k_reg, k_next;
    logic [ROOT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  held_reg, held_next;
    logic                  accept, last_pair;

    assign accept    = in_valid && !in_stall;
    assign last_pair = (i_reg == LAST_I) && (j_reg == LAST_J);
    assign in_stall  = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        held_next  = held_reg;
        cmd        = '0;
        cmd.i      = i_reg;
        cmd.j      = j_reg;
        cmd.k      = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.take = 1'b1;
                    if (in_data.kind == KIND_CHECK && status.ge2)
                    begin
                        i_next     = '0;
                        j_next     = SLOT_W'(1);
                        held_next  = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.active[i_reg] && status.active[j_reg])
                begin
                    cmd.diff   = 1'b1;
                    state_next = ST_SQX;
                end
                else
                    state_next = ST_ADV;
            end
            ST_SQX:
            begin
                cmd.sqx    = 1'b1;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                cmd.sqy    = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (status.close)
                begin
                    cmd.sqrt_init = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_SQRT;
                end
                else
                    state_next = ST_ADV;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + ROOT_CNT_W'(1);
                if (cnt_reg == '1)
                begin
                    k_next     = K_FIRST;
                    state_next = ST_SECT_V;
                end
            end
            ST_SECT_V:
            begin
                cmd.prod_v = 1'b1;
                state_next = ST_SECT_U;
            end
            ST_SECT_U:
            begin
                cmd.prod_u = 1'b1;
                k_next     = k_reg + K_W'(1);
                state_next = (k_reg == K_LAST) ? ST_EMIT_H : ST_SECT_V;
            end
            ST_EMIT_H:
            begin
                // The mirrored beat of the previous alert goes out before the new pair.
                if (!held_reg)
                    state_next = ST_EMIT_A;
                else if (status.out_free)
                begin
                    cmd.out_held = 1'b1;
                    held_next    = 1'b0;
                    state_next   = ST_EMIT_A;
                end
            end
            ST_EMIT_A:
            begin
                if (status.out_free)
                begin
                    cmd.out_a  = 1'b1;
                    held_next  = 1'b1;
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                if (last_pair)
                    state_next = ST_FINISH;
                else
                begin
                    if (j_reg == LAST_J)
                    begin
                        i_next = i_reg + SLOT_W'(1);
                        j_next = i_reg + SLOT_W'(2);
                    end
                    else
                        j_next = j_reg + SLOT_W'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_FINISH:
            begin
                if (!held_reg)
                    state_next = ST_IDLE;
                else if (status.out_free)
                begin
                    cmd.out_held = 1'b1;
                    cmd.last     = 1'b1;
                    held_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            cnt_reg   <= '0;
            held_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
            held_reg  <= held_next;
        end
    end

endmodule

@@ design/pairwise_proximity_alert_unit.sv @@
// Top level of the pairwise proximity alert unit: controller plus datapath.
// Depends on ppa_pkg, ppa_ctrl and ppa_datapath.
`timescale 1ns / 1ps

// Register and update beats are taken without stalling the input, and so is
// a check beat when fewer than two slots are active. Otherwise a check keeps
// the input stalled while it walks up to 28 slot pairs; an alerting pair needs
// 16 root iterations and 34 sector products on the one shared multiplier, and
// the walk also waits while the output is stalled. Each alerting pair gives
// two result beats, and the last one of a check carries last.
module pairwise_proximity_alert_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ppa_pkg::ppa_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output ppa_pkg::ppa_out_t out_data,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_data
);
    import ppa_pkg::*;

    ppa_cmd_t    cmd;
    ppa_status_t status;

    ppa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .status   (status),
        .cmd      (cmd)
    );

    ppa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_a || cmd.out_held) |-> status.out_free)
        else $error("result loaded while output register is blocked");
    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.out_a && cmd.out_held))
        else $error("two result loads in one cycle");
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !(cmd.sqrt_step || cmd.out_a || cmd.prod_u))
        else $error("pair work while input is open");
`endif

endmodule
